### rtl/diu_pkg.sv
// ----------------------------------------------------------------------------
// diu_pkg: shared definitions for the divide instruction unit
// Result status codes, register file geometry, program counter and instruction fields.
// ----------------------------------------------------------------------------
`default_nettype none

package diu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RegCount  = 16;
   localparam int unsigned IdxWidth  = 4;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FAULT = 2'd1;
   localparam logic [1:0] STATUS_WRITE = 2'd2;

   // program counter entry and step
   localparam logic [IdxWidth-1:0]  PC_INDEX = 4'hf;
   localparam logic [DataWidth-1:0] PC_STEP  = 32'd4;

   // instruction word fields
   localparam int unsigned UNSIGNED_BIT = 21;
   localparam int unsigned ARM_RN_POS   = 0;
   localparam int unsigned ARM_RM_POS   = 8;
   localparam int unsigned ARM_RD_POS   = 16;
   localparam int unsigned THB_RN_POS   = 16;
   localparam int unsigned THB_RM_POS   = 0;
   localparam int unsigned THB_RD_POS   = 8;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [IdxWidth-1:0]  idx_type;

endpackage

`default_nettype wire

### rtl/divide_instruction_unit.sv
// ----------------------------------------------------------------------------
// divide_instruction_unit: register file plus 32-bit integer divide
// Executes register writes and signed/unsigned divide instruction words.
// ----------------------------------------------------------------------------
// One item is handled at a time: the unit accepts the next item only once the
// result of the last one has been loaded into the output register. A register
// write goes straight to the result. A divide takes two register file reads
// through the single RAM read port (Rn, then Rm), 32 iterations of a radix-2
// restoring divider, a writeback of Rd and a writeback of the program counter
// through the single RAM write port, then the result. A zero divisor ends after
// the reads. A result held by rsp_ready keeps the next finished item waiting to
// be loaded, and the unit accepts nothing new meanwhile. The register file is
// all zeros after reset through per-entry valid bits, so no clearing pass is
// needed. The result stays in an output register while the next item is
// accepted.
`default_nettype none

module divide_instruction_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [3:0]  req_reg_index,
   input  wire logic [31:0] req_write_value,
   input  wire logic [31:0] req_instruction,
   input  wire logic        req_thumb_state,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_dest_index,
   output logic [31:0]      rsp_quotient,
   output logic [31:0]      rsp_pc_value
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD_RN = 3'd1;
   localparam logic [2:0] ST_RD_RM = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_WB    = 3'd4;
   localparam logic [2:0] ST_PC    = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   localparam int unsigned DW = diu_pkg::DataWidth;
   localparam int unsigned CntWidth = $clog2(DW);
   localparam logic [CntWidth-1:0] CNT_LAST = CntWidth'(DW - 1);

   logic [2:0]             state_ff, state_in;
   logic [diu_pkg::RegCount-1:0] valid_ff, valid_in;
   diu_pkg::word_type      pc_ff, pc_in;
   diu_pkg::idx_type       rm_ff, rm_in;
   diu_pkg::idx_type       rd_ff, rd_in;
   logic                   uns_ff, uns_in;
   logic                   neg_ff, neg_in;
   diu_pkg::word_type      dvd_ff, dvd_in;
   diu_pkg::word_type      dvs_ff, dvs_in;
   diu_pkg::word_type      rem_ff, rem_in;
   diu_pkg::word_type      quo_ff, quo_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [1:0]             status_ff, status_in;
   diu_pkg::idx_type       raddr_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff;
   diu_pkg::idx_type       rsp_dest_ff;
   diu_pkg::word_type      rsp_quot_ff;
   diu_pkg::word_type      rsp_pc_ff;

   logic                   ram_we;
   diu_pkg::idx_type       ram_waddr, ram_raddr;
   diu_pkg::word_type      ram_wdata, ram_rdata, rdata;

   diu_pkg::idx_type       dec_rn, dec_rm, dec_rd;
   diu_pkg::word_type      mag_a, mag_b, q_final;
   logic [DW:0]            shifted, diff;
   logic                   accept, out_free;

   diu_ram #(
      .WIDTH(DW),
      .DEPTH(diu_pkg::RegCount)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // field decode of the incoming instruction
   always_comb begin
      if (req_thumb_state) begin
         dec_rn = req_instruction[diu_pkg::THB_RN_POS +: diu_pkg::IdxWidth];
         dec_rm = req_instruction[diu_pkg::THB_RM_POS +: diu_pkg::IdxWidth];
         dec_rd = req_instruction[diu_pkg::THB_RD_POS +: diu_pkg::IdxWidth];
      end else begin
         dec_rn = req_instruction[diu_pkg::ARM_RN_POS +: diu_pkg::IdxWidth];
         dec_rm = req_instruction[diu_pkg::ARM_RM_POS +: diu_pkg::IdxWidth];
         dec_rd = req_instruction[diu_pkg::ARM_RD_POS +: diu_pkg::IdxWidth];
      end
   end

   // entries never written read as zero
   assign rdata = valid_ff[raddr_ff] ? ram_rdata : '0;

   // operand magnitudes for the divider
   always_comb begin
      if (uns_ff) begin
         mag_a = dvd_ff;
         mag_b = rdata;
      end else begin
         mag_a = dvd_ff[DW-1] ? (DW'(0) - dvd_ff) : dvd_ff;
         mag_b = rdata[DW-1] ? (DW'(0) - rdata) : rdata;
      end
   end

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign q_final = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      pc_in        = pc_ff;
      rm_in        = rm_ff;
      rd_in        = rd_ff;
      uns_in       = uns_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = req_reg_index;
      ram_wdata    = req_write_value;
      ram_raddr    = dec_rn;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  ram_we    = 1'b1;
                  valid_in[req_reg_index] = 1'b1;
                  if (req_reg_index == diu_pkg::PC_INDEX) begin
                     pc_in = req_write_value;
                  end
                  rd_in     = '0;
                  quo_in    = '0;
                  status_in = diu_pkg::STATUS_WRITE;
                  state_in  = ST_EMIT;
               end else begin
                  rm_in    = dec_rm;
                  rd_in    = dec_rd;
                  uns_in   = req_instruction[diu_pkg::UNSIGNED_BIT];
                  state_in = ST_RD_RN;
               end
            end
         end
         ST_RD_RN: begin
            dvd_in    = rdata;
            ram_raddr = rm_ff;
            state_in  = ST_RD_RM;
         end
         ST_RD_RM: begin
            if (rdata == '0) begin
               quo_in    = '0;
               status_in = diu_pkg::STATUS_FAULT;
               state_in  = ST_EMIT;
            end else begin
               neg_in    = !uns_ff && (dvd_ff[DW-1] ^ rdata[DW-1]);
               dvs_in    = mag_b;
               quo_in    = mag_a;
               rem_in    = '0;
               cnt_in    = '0;
               status_in = diu_pkg::STATUS_DONE;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!diff[DW]) begin
               rem_in = diff[DW-1:0];
            end else begin
               rem_in = shifted[DW-1:0];
            end
            quo_in = {quo_ff[DW-2:0], !diff[DW]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            ram_we    = 1'b1;
            ram_waddr = rd_ff;
            ram_wdata = q_final;
            valid_in[rd_ff] = 1'b1;
            if (rd_ff == diu_pkg::PC_INDEX) begin
               pc_in = q_final;
            end
            quo_in   = q_final;
            neg_in   = 1'b0;
            state_in = ST_PC;
         end
         ST_PC: begin
            ram_we    = 1'b1;
            ram_waddr = diu_pkg::PC_INDEX;
            ram_wdata = pc_ff + diu_pkg::PC_STEP;
            valid_in[diu_pkg::PC_INDEX] = 1'b1;
            pc_in     = pc_ff + diu_pkg::PC_STEP;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rm_ff     <= rm_in;
      rd_ff     <= rd_in;
      uns_ff    <= uns_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      raddr_ff  <= ram_raddr;
   end

   // result register, loaded when the item is finished
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_dest_ff   <= rd_ff;
         rsp_quot_ff   <= quo_ff;
         rsp_pc_ff     <= pc_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_dest_index = rsp_dest_ff;
   assign rsp_quotient   = rsp_quot_ff;
   assign rsp_pc_value   = rsp_pc_ff;

endmodule

`default_nettype wire

### rtl/diu_ram.sv
// ----------------------------------------------------------------------------
// diu_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module diu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/divide_instruction_unit_checker.sv
// ----------------------------------------------------------------------------
// divide_instruction_unit_checker: port-level checks
// Watches the result channel of the divide instruction unit.
// ----------------------------------------------------------------------------
`default_nettype none

module divide_instruction_unit_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [3:0]  rsp_dest_index,
   input wire logic [31:0] rsp_quotient,
   input wire logic [31:0] rsp_pc_value
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_quotient) && $stable(rsp_pc_value) && $stable(rsp_dest_index))
      else $error("stalled result item changed");

   // only defined status codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == diu_pkg::STATUS_DONE
         || rsp_status == diu_pkg::STATUS_FAULT || rsp_status == diu_pkg::STATUS_WRITE)
      else $error("undefined status code");

   // register write reports no destination and no quotient
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == diu_pkg::STATUS_WRITE |->
         rsp_dest_index == '0 && rsp_quotient == '0)
      else $error("register write result carries divide fields");

   // a fault reports a zero quotient
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == diu_pkg::STATUS_FAULT |-> rsp_quotient == '0)
      else $error("fault result with nonzero quotient");

   // the unit takes no new item straight after accepting one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one still in work");

endmodule

bind divide_instruction_unit divide_instruction_unit_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_dest_index (rsp_dest_index),
   .rsp_quotient   (rsp_quotient),
   .rsp_pc_value   (rsp_pc_value)
);

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the divide instruction unit
// Drives register writes and divide instruction words over the req_ channel,
// mirrors the register file in a predictor and checks every rsp_ item field
// by field. Directed cases cover the field extremes and the corner cases of
// the divider; three random phases follow with varying idle patterns.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // item kinds on req_mode
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_DIVIDE = 1'b1;

   // cycles to let pass after the last result (divide latency plus margin)
   localparam int DrainCycles = 60;

   typedef struct {
      logic              mode;
      diu_pkg::idx_type  reg_index;
      diu_pkg::word_type write_value;
      diu_pkg::word_type instruction;
      logic              thumb_state;
   } diu_item_type;

   typedef struct {
      logic [1:0]        status;
      diu_pkg::idx_type  dest_index;
      diu_pkg::word_type quotient;
      diu_pkg::word_type pc_value;
   } diu_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [3:0]  req_reg_index = '0;
   logic [31:0] req_write_value = '0;
   logic [31:0] req_instruction = '0;
   logic        req_thumb_state = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_dest_index;
   logic [31:0] rsp_quotient;
   logic [31:0] rsp_pc_value;

   // shadow register file and results still owed by the block
   diu_pkg::word_type shadow_regs [diu_pkg::RegCount];
   diu_result_type    pending_results [$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   divide_instruction_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_reg_index   (req_reg_index),
      .req_write_value (req_write_value),
      .req_instruction (req_instruction),
      .req_thumb_state (req_thumb_state),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_quotient    (rsp_quotient),
      .rsp_pc_value    (rsp_pc_value)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // quotient truncated toward zero; most negative by minus one wraps back
   function automatic diu_pkg::word_type divide_word(diu_pkg::word_type a,
                                                     diu_pkg::word_type b,
                                                     logic is_unsigned);
      logic              neg;
      diu_pkg::word_type ma, mb, q;
      if (is_unsigned)
         return a / b;
      neg = a[31] ^ b[31];
      ma  = a[31] ? (32'd0 - a) : a;
      mb  = b[31] ? (32'd0 - b) : b;
      q   = ma / mb;
      return neg ? (32'd0 - q) : q;
   endfunction

   // updates the shadow register file and returns the result the item owes
   function automatic diu_result_type apply_item(diu_item_type it);
      diu_result_type    res;
      diu_pkg::idx_type  rn, rm, rd;
      diu_pkg::word_type dividend, divisor, q;
      res = '{status: diu_pkg::STATUS_WRITE, dest_index: '0, quotient: '0, pc_value: '0};
      if (it.mode == MODE_WRITE) begin
         shadow_regs[it.reg_index] = it.write_value;
         res.pc_value = shadow_regs[diu_pkg::PC_INDEX];
         return res;
      end
      if (it.thumb_state) begin
         rn = it.instruction[diu_pkg::THB_RN_POS +: diu_pkg::IdxWidth];
         rm = it.instruction[diu_pkg::THB_RM_POS +: diu_pkg::IdxWidth];
         rd = it.instruction[diu_pkg::THB_RD_POS +: diu_pkg::IdxWidth];
      end else begin
         rn = it.instruction[diu_pkg::ARM_RN_POS +: diu_pkg::IdxWidth];
         rm = it.instruction[diu_pkg::ARM_RM_POS +: diu_pkg::IdxWidth];
         rd = it.instruction[diu_pkg::ARM_RD_POS +: diu_pkg::IdxWidth];
      end
      dividend = shadow_regs[rn];
      divisor  = shadow_regs[rm];
      res.dest_index = rd;
      if (divisor == '0) begin
         // fault: nothing written, PC unchanged
         res.status   = diu_pkg::STATUS_FAULT;
         res.pc_value = shadow_regs[diu_pkg::PC_INDEX];
         return res;
      end
      q = divide_word(dividend, divisor, it.instruction[diu_pkg::UNSIGNED_BIT]);
      shadow_regs[rd]                = q;
      shadow_regs[diu_pkg::PC_INDEX] = shadow_regs[diu_pkg::PC_INDEX] + diu_pkg::PC_STEP;
      res.status   = diu_pkg::STATUS_DONE;
      res.quotient = q;
      res.pc_value = shadow_regs[diu_pkg::PC_INDEX];
      return res;
   endfunction

   // random instruction word with the register fields placed for the layout
   function automatic diu_pkg::word_type make_insn(diu_pkg::idx_type rn,
                                                   diu_pkg::idx_type rm,
                                                   diu_pkg::idx_type rd,
                                                   logic is_unsigned, logic thumb);
      diu_pkg::word_type w;
      w = $urandom;
      if (thumb) begin
         w[diu_pkg::THB_RN_POS +: diu_pkg::IdxWidth] = rn;
         w[diu_pkg::THB_RM_POS +: diu_pkg::IdxWidth] = rm;
         w[diu_pkg::THB_RD_POS +: diu_pkg::IdxWidth] = rd;
      end else begin
         w[diu_pkg::ARM_RN_POS +: diu_pkg::IdxWidth] = rn;
         w[diu_pkg::ARM_RM_POS +: diu_pkg::IdxWidth] = rm;
         w[diu_pkg::ARM_RD_POS +: diu_pkg::IdxWidth] = rd;
      end
      w[diu_pkg::UNSIGNED_BIT] = is_unsigned;
      return w;
   endfunction

   // operand values weighted toward the interesting corners
   function automatic diu_pkg::word_type pick_operand();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return diu_pkg::word_type'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   // drive one item; unused fields carry random bits
   task automatic send_item(diu_item_type it);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_mode        = it.mode;
      req_reg_index   = it.reg_index;
      req_write_value = it.write_value;
      req_instruction = it.instruction;
      req_thumb_state = it.thumb_state;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_item(it));
   endtask

   task automatic write_reg(diu_pkg::idx_type idx, diu_pkg::word_type value);
      diu_item_type it;
      it = '{mode: MODE_WRITE, reg_index: idx, write_value: value,
             instruction: $urandom, thumb_state: 1'($urandom_range(1))};
      send_item(it);
   endtask

   task automatic exec_divide(diu_pkg::word_type insn, logic thumb);
      diu_item_type it;
      it = '{mode: MODE_DIVIDE, reg_index: diu_pkg::idx_type'($urandom_range(15)),
             write_value: $urandom, instruction: insn, thumb_state: thumb};
      send_item(it);
   endtask

   // sender holds off until the block has nothing left owed
   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_write();
      write_reg(4'd0, 32'hFFFF_FFFF);
      write_reg(diu_pkg::PC_INDEX, 32'h0000_0100);
   endtask

   task automatic test_unsigned_divide();
      write_reg(4'd1, 32'hFFFF_FFFF);
      write_reg(4'd2, 32'd3);
      exec_divide(make_insn(4'd1, 4'd2, 4'd3, 1'b1, 1'b0), 1'b0);
      exec_divide(make_insn(4'd1, 4'd2, 4'd4, 1'b1, 1'b1), 1'b1);
   endtask

   task automatic test_signed_divide();
      write_reg(4'd5, 32'hFFFF_FFF9);   // -7
      write_reg(4'd6, 32'd2);
      exec_divide(make_insn(4'd5, 4'd6, 4'd7, 1'b0, 1'b0), 1'b0);
      exec_divide(make_insn(4'd6, 4'd5, 4'd7, 1'b0, 1'b1), 1'b1);
   endtask

   // most negative over minus one, signed and unsigned
   task automatic test_most_negative();
      write_reg(4'd8, 32'h8000_0000);
      write_reg(4'd9, 32'hFFFF_FFFF);
      exec_divide(make_insn(4'd8, 4'd9, 4'd10, 1'b0, 1'b0), 1'b0);
      exec_divide(make_insn(4'd8, 4'd9, 4'd11, 1'b1, 1'b1), 1'b1);
   endtask

   task automatic test_zero_divisor();
      write_reg(4'd12, 32'h0000_0000);
      exec_divide(make_insn(4'd1, 4'd12, 4'd13, 1'b1, 1'b0), 1'b0);
      exec_divide(make_insn(4'd5, 4'd12, diu_pkg::PC_INDEX, 1'b0, 1'b1), 1'b1);
   endtask

   // PC as source and destination, plus the all-zero and all-one words
   task automatic test_program_counter();
      exec_divide(32'hFFFF_FFFF, 1'b0);
      exec_divide(32'h0000_0000, 1'b0);
      exec_divide(32'hFFFF_FFFF, 1'b1);
      exec_divide(make_insn(4'd1, diu_pkg::PC_INDEX, 4'd14, 1'b1, 1'b1), 1'b1);
   endtask

   // mostly write-write-divide sequences, the rest loose items
   task automatic test_random(int count, int s_pct, int r_pct);
      int               sent;
      diu_pkg::idx_type rn, rm, rd;
      logic             thumb;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < count) begin
         thumb = 1'($urandom_range(1));
         if ($urandom_range(99) < 60) begin
            rn = diu_pkg::idx_type'($urandom_range(15));
            rm = diu_pkg::idx_type'($urandom_range(15));
            rd = diu_pkg::idx_type'($urandom_range(15));
            write_reg(rn, pick_operand());
            write_reg(rm, ($urandom_range(9) == 0) ? 32'd0 : (pick_operand() | 32'd1));
            exec_divide(make_insn(rn, rm, rd, 1'($urandom_range(1)), thumb), thumb);
            sent += 3;
         end else if ($urandom_range(2) == 0) begin
            write_reg(diu_pkg::idx_type'($urandom_range(15)), pick_operand());
            sent++;
         end else begin
            exec_divide($urandom, thumb);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      diu_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no expectation waiting");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("dest_index", 32'(want.dest_index), 32'(rsp_dest_index));
            check_field("quotient", want.quotient, rsp_quotient);
            check_field("pc_value", want.pc_value, rsp_pc_value);
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_ready = !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      foreach (shadow_regs[i])
         shadow_regs[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_write();
      test_unsigned_divide();
      test_signed_divide();
      test_most_negative();
      test_zero_divisor();
      test_program_counter();
      wait_results_drained();

      test_random(400, 21, 69);
      wait_results_drained();
      test_random(400, 69, 21);
      wait_results_drained();
      test_random(400, 0, 0);
      wait_results_drained();

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // run limit
   initial begin
      #8ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
